>>> hw/rtl/anxb_pkg.sv
// shared types and constants for the annex b nal unit splitter
// used by the front end, the command queue, the back end and the top level
`timescale 1ns / 1ps
package anxb_pkg;

  localparam logic [7:0] TYPE_MASK   = 8'h1F;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_ONE    = 8'h01;
  localparam logic [7:0] BYTE_EPB    = 8'h03;
  localparam logic [1:0] ZERO_SAT    = 2'd3;
  localparam int         MAX_RESULTS = 4;
  localparam int         SLOT_W      = $clog2(MAX_RESULTS);
  localparam int         CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int         QUEUE_DEPTH = 4;
  localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       first_in_unit;
    logic       last_in_unit;
    logic [4:0] unit_type;
  } res_t;

  // all result words caused by one input byte
  typedef struct packed {
    res_t [MAX_RESULTS-1:0] slot;
    logic [CNT_W-1:0]       count;
  } cmd_t;

endpackage

>>> hw/rtl/anxb_front.sv
// front end: accepts stream bytes, tracks start codes and zero runs, and
// builds the list of result words for each byte; uses anxb_pkg
`timescale 1ns / 1ps
module anxb_front
  import anxb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [1:0] held_zero_count, held_zero_count_next;
  logic       inside_unit, inside_unit_next;
  logic       header_next, header_next_next;
  logic [4:0] current_type, current_type_next;
  logic       accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (push_cmd.count != '0);

  // classify the byte and list its result words
  always_comb begin
    logic [CNT_W-1:0] n;
    logic             hdr;
    logic [4:0]       typ;
    logic             give_b;
    n                    = '0;
    hdr                  = header_next;
    typ                  = current_type;
    give_b               = 1'b0;
    held_zero_count_next = held_zero_count;
    inside_unit_next     = inside_unit;
    push_cmd             = '0;

    if (data_byte == BYTE_ZERO) begin
      if (held_zero_count != ZERO_SAT) held_zero_count_next = held_zero_count + 2'd1;
    end else if (data_byte == BYTE_ONE && held_zero_count >= 2'd2) begin
      // start code: close the open unit if it holds bytes
      if (inside_unit && !header_next) begin
        push_cmd.slot[n[SLOT_W-1:0]] = '{out_byte: BYTE_ZERO, byte_valid: 1'b0,
            first_in_unit: 1'b0, last_in_unit: 1'b1, unit_type: typ};
        n = n + 1'b1;
      end
      inside_unit_next     = 1'b1;
      hdr                  = 1'b1;
      held_zero_count_next = 2'd0;
    end else if (inside_unit) begin
      // flush held zeros, then the byte unless it is an emulation prevention byte
      for (int i = 0; i < 3; i++) begin
        if (i < int'(held_zero_count)) begin
          push_cmd.slot[n[SLOT_W-1:0]] = '{out_byte: BYTE_ZERO, byte_valid: 1'b1,
              first_in_unit: hdr, last_in_unit: 1'b0, unit_type: hdr ? 5'd0 : typ};
          if (hdr) begin
            typ = 5'd0;
            hdr = 1'b0;
          end
          n = n + 1'b1;
        end
      end
      held_zero_count_next = 2'd0;
      give_b = !(data_byte == BYTE_EPB && held_zero_count >= 2'd2);
      if (give_b) begin
        push_cmd.slot[n[SLOT_W-1:0]] = '{out_byte: data_byte, byte_valid: 1'b1,
            first_in_unit: hdr, last_in_unit: 1'b0,
            unit_type: hdr ? 5'(data_byte & TYPE_MASK) : typ};
        if (hdr) begin
          typ = 5'(data_byte & TYPE_MASK);
          hdr = 1'b0;
        end
        n = n + 1'b1;
      end
    end else begin
      held_zero_count_next = 2'd0;
    end

    // end of stream: close the unit and return to reset state
    if (end_of_stream) begin
      if (inside_unit_next && !hdr) begin
        if (n != '0 && push_cmd.slot[SLOT_W'(n - 1'b1)].byte_valid) begin
          push_cmd.slot[SLOT_W'(n - 1'b1)].last_in_unit = 1'b1;
        end else if (n < CNT_W'(MAX_RESULTS)) begin
          push_cmd.slot[n[SLOT_W-1:0]] = '{out_byte: BYTE_ZERO, byte_valid: 1'b0,
              first_in_unit: 1'b0, last_in_unit: 1'b1, unit_type: typ};
          n = n + 1'b1;
        end
      end
      held_zero_count_next = 2'd0;
      inside_unit_next     = 1'b0;
      hdr                  = 1'b0;
      typ                  = 5'd0;
    end

    push_cmd.count    = n;
    header_next_next  = hdr;
    current_type_next = typ;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_zero_count <= 2'd0;
      inside_unit     <= 1'b0;
      header_next     <= 1'b0;
      current_type    <= 5'd0;
    end else if (accept) begin
      held_zero_count <= held_zero_count_next;
      inside_unit     <= inside_unit_next;
      header_next     <= header_next_next;
      current_type    <= current_type_next;
    end
  end

endmodule

>>> hw/rtl/anxb_queue.sv
// command queue between front end and back end
// small register fifo of cmd_t entries; uses anxb_pkg
`timescale 1ns / 1ps
module anxb_queue
  import anxb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

>>> hw/rtl/anxb_back.sv
// back end: walks the result words of the head command, one word a cycle
// while out_ready does not stall it, into the output register; uses anxb_pkg
`timescale 1ns / 1ps
module anxb_back
  import anxb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  cmd_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic [SLOT_W-1:0] sel;
  logic              load;
  logic              last_slot;

  assign load      = !out_valid || out_ready;
  assign last_slot = (CNT_W'(sel) + 1'b1) == head.count;
  assign pop       = load && !empty && last_slot;

  // slot select and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) sel <= last_slot ? '0 : sel + 1'b1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load && !empty) out_res <= head.slot[sel];
  end

endmodule

>>> hw/rtl/annexb_nal_unit_splitter.sv
// Annex B NAL unit splitter. A byte is accepted in any cycle in which the
// 4-entry command queue has room, so the input runs at one byte per clock
// while the queue has room. Each byte yields zero to four result words (held
// zeros, the byte itself, end markers); the back end delivers one word per
// clock from the queue head while out_ready does not stall it. A byte's words
// pass through the command queue and then the single output register. Start
// codes are removed, emulation prevention bytes are dropped, and each unit
// ends with last_in_unit on its final word.
// depends on anxb_pkg, anxb_front, anxb_queue, anxb_back
`timescale 1ns / 1ps
module annexb_nal_unit_splitter
  import anxb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       first_in_unit,
  output logic       last_in_unit,
  output logic [4:0] unit_type,
  output logic       out_valid,
  input  logic       out_ready
);

  logic push, full, pop, empty;
  cmd_t push_cmd, head;
  res_t out_res;

  // parse and classify
  anxb_front u_front (
    .clk, .rst, .data_byte, .end_of_stream, .in_valid, .in_ready,
    .queue_full(full), .push, .push_cmd
  );

  // decouple front and back
  anxb_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full, .pop, .empty, .head
  );

  // emit result words
  anxb_back u_back (
    .clk, .rst, .empty, .head, .pop, .out_valid, .out_ready, .out_res
  );

  assign out_byte      = out_res.out_byte;
  assign byte_valid    = out_res.byte_valid;
  assign first_in_unit = out_res.first_in_unit;
  assign last_in_unit  = out_res.last_in_unit;
  assign unit_type     = out_res.unit_type;

endmodule

>>> hw/rtl/anxb_checker.sv
// port-level checks for the annex b nal unit splitter, bound to the top level
// sees only top-level ports
`timescale 1ns / 1ps
module anxb_checker (
  input logic       clk,
  input logic       rst,
  input logic [7:0] data_byte,
  input logic       end_of_stream,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       first_in_unit,
  input logic       last_in_unit,
  input logic [4:0] unit_type,
  input logic       out_valid,
  input logic       out_ready
);

  // a waiting input word stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(end_of_stream))
    else $error("input word changed while waiting");

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a header word carries a byte
  a_first_is_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_in_unit |-> byte_valid)
    else $error("header flag on a bare end marker");

  // a bare end marker closes a unit and carries zero
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last_in_unit && out_byte == 8'h00 && !first_in_unit)
    else $error("malformed end marker");

  // the header word's type comes from its low five bits
  a_header_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_in_unit |-> unit_type == out_byte[4:0])
    else $error("unit type does not match header byte");

endmodule

bind annexb_nal_unit_splitter anxb_checker u_anxb_checker (.*);

>>> tb/tb.sv
// self-checking testbench for annexb_nal_unit_splitter
// drives annex b byte streams, predicts every nal word and checks each output word
// depends on anxb_pkg and the annexb_nal_unit_splitter rtl
`timescale 1ns / 1ps
module tb;
  import anxb_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic [7:0] data_byte;
  logic       end_of_stream;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       first_in_unit;
  logic       last_in_unit;
  logic [4:0] unit_type;
  logic       out_valid;
  logic       out_ready;

  // predicted nal words, oldest first
  res_t       nal_expect[$];
  logic [7:0] seq[$];

  // predictor copy of the splitter state
  logic [1:0] zero_run;
  logic       unit_open;
  logic       header_due;
  logic [4:0] open_type;

  bit idle_on;
  int n_errors;
  int n_sent;
  int items_in_units;
  int n_checked;
  int n_headers;
  int n_epb_dropped;
  int n_streams;

  annexb_nal_unit_splitter dut (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .first_in_unit(first_in_unit),
    .last_in_unit (last_in_unit),
    .unit_type    (unit_type),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the splitter hangs
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 30) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("word %0d %s got %0h want %0h", n_checked, name, got, want));
    end
  endtask

  // payload byte of the open unit; the header byte sets the unit type
  function automatic res_t unit_word(input logic [7:0] b);
    res_t w;
    w = '0;
    w.out_byte = b;
    w.byte_valid = 1'b1;
    if (header_due) begin
      w.first_in_unit = 1'b1;
      open_type = 5'(b & TYPE_MASK);
      header_due = 1'b0;
      n_headers++;
    end
    w.unit_type = open_type;
    return w;
  endfunction

  // bare word that closes the open unit
  function automatic res_t end_marker();
    res_t w;
    w = '0;
    w.last_in_unit = 1'b1;
    w.unit_type = open_type;
    return w;
  endfunction

  // words caused by one accepted byte
  task automatic predict_nal_words(input logic [7:0] b, input logic eos);
    res_t step_q[$];
    int   run;
    run = int'(zero_run);
    if (unit_open || (b == BYTE_ONE && zero_run >= 2)) begin
      items_in_units++;
    end
    if (b == BYTE_ZERO) begin
      if (zero_run != ZERO_SAT) zero_run = zero_run + 2'd1;
    end else if (b == BYTE_ONE && zero_run >= 2) begin
      // start code closes a unit that holds bytes and opens the next
      if (unit_open && !header_due) step_q = {step_q, end_marker()};
      unit_open = 1'b1;
      header_due = 1'b1;
      zero_run = '0;
    end else if (unit_open) begin
      // held zeros belong to the payload; an escape byte after two zeros goes away
      repeat (run) step_q = {step_q, unit_word(BYTE_ZERO)};
      zero_run = '0;
      if (b == BYTE_EPB && run >= 2) begin
        n_epb_dropped++;
      end else begin
        step_q = {step_q, unit_word(b)};
      end
    end else begin
      zero_run = '0;
    end
    // end of stream flags the last byte word or appends a bare marker
    if (eos) begin
      if (unit_open && !header_due) begin
        if (step_q.size() > 0 && step_q[step_q.size()-1].byte_valid) begin
          step_q[step_q.size()-1].last_in_unit = 1'b1;
        end else begin
          step_q = {step_q, end_marker()};
        end
      end
      zero_run = '0;
      unit_open = 1'b0;
      header_due = 1'b0;
      open_type = '0;
    end
    nal_expect = {nal_expect, step_q};
  endtask

  // send one byte, first dropping in_valid for a random gap when idling is on
  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    predict_nal_words(b, eos);
  endtask

  task automatic send_seq(input bit eos_last);
    foreach (seq[i]) send_word(seq[i], eos_last && (i == seq.size() - 1));
  endtask

  // stop sending until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (nal_expect.size() != 0) @(posedge clk);
  endtask

  // payload mix rich in zeros, escapes and start code bytes
  function automatic logic [7:0] payload_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return BYTE_ZERO;
    if (pick < 45) return BYTE_EPB;
    if (pick < 50) return BYTE_ONE;
    return 8'($urandom_range(0, 255));
  endfunction

  // junk before the first start code, both start code forms, empty unit, header types
  task automatic test_start_codes();
    idle_on = 1'b0;
    seq = '{8'hAB, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF, 8'h00, 8'h00, 8'h01,
            8'h00, 8'h00, 8'h01, 8'h3F, 8'h80};
    send_seq(1'b1);
    wait_drained();
  endtask

  // escape removal, second escape kept, saturated zero run, trailing escape at end
  task automatic test_emulation_prevention();
    idle_on = 1'b1;
    seq = '{8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h03, 8'h03, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h03};
    send_seq(1'b1);
    wait_drained();
  endtask

  // well-formed streams with random content, closed by end of stream most of the time
  task automatic test_random_streams();
    int n_units;
    while (n_sent < 230) begin
      idle_on = ($urandom_range(0, 3) != 0);
      seq.delete();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) seq = {seq, 8'($urandom_range(0, 255))};
      end
      n_units = $urandom_range(1, 4);
      repeat (n_units) begin
        if ($urandom_range(0, 1) == 1) seq = {seq, BYTE_ZERO};
        seq = {seq, BYTE_ZERO, BYTE_ZERO, BYTE_ONE};
        if ($urandom_range(0, 7) != 0) seq = {seq, 8'($urandom_range(0, 255))};
        repeat ($urandom_range(0, 10)) seq = {seq, payload_byte()};
      end
      repeat ($urandom_range(0, 2)) seq = {seq, BYTE_ZERO};
      send_seq($urandom_range(0, 4) != 0);
      n_streams++;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // unstructured bytes with occasional end of stream
  task automatic test_noise();
    idle_on = 1'b1;
    repeat (60) begin
      send_word($urandom_range(0, 1) ? payload_byte() : 8'($urandom_range(0, 255)),
                $urandom_range(0, 15) == 0);
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // output side: when idling is on, stall for a random gap before taking each word
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each delivered word with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (nal_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected word out_byte %0h last %0b", out_byte,
                                  last_in_unit));
      end else begin
        want = nal_expect.pop_front();
        check_field("out_byte", out_byte, want.out_byte);
        check_field("byte_valid", 8'(byte_valid), 8'(want.byte_valid));
        check_field("first_in_unit", 8'(first_in_unit), 8'(want.first_in_unit));
        check_field("last_in_unit", 8'(last_in_unit), 8'(want.last_in_unit));
        check_field("unit_type", 8'(unit_type), 8'(want.unit_type));
      end
      n_checked++;
    end
  end

  // reset, run the tests in turn, then judge
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    end_of_stream = 1'b0;
    idle_on = 1'b0;
    zero_run = '0;
    unit_open = 1'b0;
    header_due = 1'b0;
    open_type = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_start_codes();
    test_emulation_prevention();
    test_random_streams();
    test_noise();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d bytes (%0d inside units) in %0d random streams plus noise, %0d words checked",
             n_sent, items_in_units, n_streams, n_checked);
    $display("%0d unit headers seen, %0d escape bytes removed, %0d mismatches",
             n_headers, n_epb_dropped, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/anxb_pkg.sv
hw/rtl/anxb_front.sv
hw/rtl/anxb_queue.sv
hw/rtl/anxb_back.sv
hw/rtl/annexb_nal_unit_splitter.sv
hw/rtl/anxb_checker.sv
tb/tb.sv
